// ===== rtl/core/kst_pkg.sv =====
// Package for the key state and auto-repeat block.
// Holds field widths, register indexes, reset values and the transfer payload types.
// No dependencies.
package kst_pkg;

    localparam int KEY_W            = 4;
    localparam int MAP_W            = 14;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int TICK_W           = 16;

    localparam int KEY_COUNT_DEF      = 14;
    localparam int BLACKOUT_INDEX_DEF = 11;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK   = 2'd2;

    localparam logic [TICK_W-1:0] RESET_DELAY  = 16'd600;
    localparam logic [TICK_W-1:0] RESET_PERIOD = 16'd40;
    localparam logic [MAP_W-1:0]  RESET_MASK   = 14'd10239;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key_index;
        logic             pressed;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_pressed;
        logic             repeated;
        logic [MAP_W-1:0] held_map;
        logic             blackout_changed;
        logic             blackout_level;
    } result_t;

endpackage

// ===== rtl/core/kst_engine.sv =====
// Key state engine: configuration registers, held-key map, repeat timer and blackout level.
// Computes the result of one item and commits the state update when fired.
// Depends on kst_pkg.
module kst_engine #(
    parameter int KEY_COUNT      = kst_pkg::KEY_COUNT_DEF,
    parameter int BLACKOUT_INDEX = kst_pkg::BLACKOUT_INDEX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kst_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          fire,
    input  kst_pkg::item_t                item,
    output logic                          res_valid,
    output kst_pkg::result_t              res
);
    import kst_pkg::*;

    localparam int MAP_KEYS = (KEY_COUNT < MAP_W) ? KEY_COUNT : MAP_W;
    localparam logic [MAP_W-1:0] KNOWN_MASK = MAP_W'((32'd1 << MAP_KEYS) - 32'd1);
    localparam logic [KEY_W-1:0] BLACKOUT_KEY = KEY_W'(BLACKOUT_INDEX);

    logic [TICK_W-1:0] delay_reg;
    logic [TICK_W-1:0] period_reg;
    logic [MAP_W-1:0]  mask_reg;

    logic [MAP_W-1:0]  held_reg, held_next;
    logic              running_reg, running_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [KEY_W-1:0]  rkey_reg, rkey_next;
    logic              seen_reg, seen_next;

    logic [MAP_W-1:0]  key_bit;
    logic              repeats;
    logic              rkey_held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= RESET_DELAY;
            period_reg <= RESET_PERIOD;
            mask_reg   <= RESET_MASK;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REPEAT_DELAY:  delay_reg  <= cfg_data;
                REG_REPEAT_PERIOD: period_reg <= cfg_data;
                REG_REPEAT_MASK:   mask_reg   <= cfg_data[MAP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        key_bit   = (MAP_W'(1) << item.key_index) & KNOWN_MASK;
        repeats   = |(key_bit & mask_reg);
        rkey_held = |(held_reg & (MAP_W'(1) << rkey_reg));

        held_next    = held_reg;
        running_next = running_reg;
        ticks_next   = ticks_reg;
        rkey_next    = rkey_reg;
        seen_next    = seen_reg;

        res_valid            = 1'b0;
        res.key              = item.key_index;
        res.is_pressed       = item.pressed;
        res.repeated         = 1'b0;
        res.blackout_changed = 1'b0;

        case (item.op)
            OP_KEY:
            begin
                res_valid = 1'b1;
                if (item.key_index == BLACKOUT_KEY)
                begin
                    res.blackout_changed = (seen_reg != item.pressed);
                    seen_next            = item.pressed;
                end
                held_next = item.pressed ? (held_reg | key_bit) : (held_reg & ~key_bit);
                if (repeats)
                begin
                    running_next = item.pressed;
                    if (item.pressed)
                    begin
                        ticks_next = delay_reg;
                        rkey_next  = item.key_index;
                    end
                end
            end
            OP_TICK:
            begin
                res.key        = rkey_reg;
                res.is_pressed = 1'b1;
                res.repeated   = 1'b1;
                if (running_reg)
                begin
                    if (ticks_reg > TICK_W'(1))
                    begin
                        ticks_next = ticks_reg - TICK_W'(1);
                    end
                    else
                    begin
                        if (rkey_reg == BLACKOUT_KEY)
                        begin
                            res.blackout_changed = !seen_reg;
                            seen_next            = 1'b1;
                        end
                        if (!rkey_held)
                        begin
                            running_next = 1'b0;
                            ticks_next   = '0;
                        end
                        else
                        begin
                            ticks_next = period_reg;
                            res_valid  = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        res.held_map       = held_next;
        res.blackout_level = seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            running_reg <= 1'b0;
            ticks_reg   <= '0;
            rkey_reg    <= '0;
            seen_reg    <= 1'b0;
        end
        else if (fire)
        begin
            held_reg    <= held_next;
            running_reg <= running_next;
            ticks_reg   <= ticks_next;
            rkey_reg    <= rkey_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

// ===== rtl/core/key_state_and_autorepeat.sv =====
// Key state and auto-repeat block: input register, state engine and result register.
// A result passes through the input register and then the result register after the input transfer.
// Throughput: one item per cycle while result_stall does not hold the result register.
// Reset clears the held map, the repeat timer, the blackout level and the pipeline.
// Reset loads the repeat delay, repeat period and repeatable mask defaults.
// Depends on kst_pkg and kst_engine.
module key_state_and_autorepeat #(
    parameter int KEY_COUNT      = kst_pkg::KEY_COUNT_DEF,
    parameter int BLACKOUT_INDEX = kst_pkg::BLACKOUT_INDEX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [kst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kst_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  kst_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output kst_pkg::result_t              result
);
    import kst_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;

    logic    advance;
    logic    fire;
    logic    res_valid;
    result_t res;

    assign advance    = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;

    kst_engine #(
        .KEY_COUNT      (KEY_COUNT),
        .BLACKOUT_INDEX (BLACKOUT_INDEX)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= fire && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
        if (fire)
        begin
            out_item_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// ===== rtl/core/kst_checker.sv =====
// Port-level checker for the key state and auto-repeat block, with its bind statement.
// Depends on kst_pkg and key_state_and_autorepeat.
module kst_port_checker #(
    parameter int BLACKOUT_INDEX = kst_pkg::BLACKOUT_INDEX_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input kst_pkg::result_t result
);
    import kst_pkg::*;

    // A repeat is always reported as a press.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.repeated |-> result.is_pressed)
        else $error("repeat result not marked as pressed");

    // Only the blackout key can flag a blackout level change.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.blackout_changed |-> result.key == KEY_W'(BLACKOUT_INDEX))
        else $error("blackout change flagged for another key");

    // A fresh result follows a matching input transfer through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("result appeared without a matching input transfer");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind key_state_and_autorepeat kst_port_checker #(
    .BLACKOUT_INDEX (BLACKOUT_INDEX)
) u_kst_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
